/* rtl/core/fspc_pkg.sv */
// Package with types, constants and status codes for the flow stage packet counter.
`default_nettype none
package fspc_pkg;
    localparam int TableEntries = 64;
    localparam int CounterBits  = 32;
    localparam int Stages       = 5;
    localparam int CountW       = $clog2(TableEntries + 1);
    localparam int SlotW        = (TableEntries > 1) ? $clog2(TableEntries) : 1;

    localparam logic [2:0] ST_COUNTED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_IGNORED  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_DUMP     = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    localparam logic       FUNC_COUNT = 1'b0;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef logic [CounterBits-1:0] cnt_t;

    typedef struct packed {
        logic [7:0]  proto;
        logic [31:0] saddr;
        logic [15:0] sport;
        logic [31:0] daddr;
        logic [15:0] dport;
    } key_t;

    typedef struct packed {
        logic        func;
        logic [2:0]  stage;
        logic [7:0]  ip_protocol;
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  flow_protocol;
        logic [31:0] flow_src_addr;
        logic [15:0] flow_src_port;
        logic [31:0] flow_dst_addr;
        logic [15:0] flow_dst_port;
        logic [31:0] count_eth_recv;
        logic [31:0] count_gro_recv;
        logic [31:0] count_netif_recv;
        logic [31:0] count_tcp_recv;
        logic [31:0] count_xmit;
        logic        last;
    } rsp_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic       rotate;  // shift the ring by one position
        logic       hit_chk; // unused by the cells; the controller compares the head key
        logic       inc;     // bump the counter of the selected stage at the head
        logic       load;    // head cell takes the new key with cleared counters
        logic [2:0] stage;
    } cell_cmd_t;

    // Contents of one flow slot handed along the ring.
    typedef struct packed {
        key_t key;
        cnt_t [Stages-1:0] cnt;
    } slot_t;

    function automatic logic [31:0] sat32(input cnt_t c);
        if (CounterBits > 32 && (c >> 32) != '0)
            return 32'hFFFF_FFFF;
        return 32'(c);
    endfunction
endpackage
`default_nettype wire

/* rtl/core/flow_stage_packet_counter.sv */
// Top level of the flow stage packet counter: APB register, controller and cell ring.
//
//  Channel | Direction | Handshake         | Payload
//  in      | input     | in_valid/in_stall | fspc_pkg::req_t
//  out     | output    | out_valid/out_stall | fspc_pkg::rsp_t
//  apb     | input     | psel/penable/pready | tracing_enabled at address 0
//
// The flow table is a ring of TableEntries cells that rotates by one slot per
// cycle while a rotate is commanded; the cell at the head is the only one that is
// compared or updated. A count request turns the ring once around to slot 0, or
// not at all when its flow sits in slot 0; no new request is taken until then.
// A dump emits one flow per rotation, then turns the ring on back to slot 0.
// Reset clears the flow count and the control state; the cells need no reset.
// A held result stalls the dump walk and blocks new requests until it is taken.
`default_nettype none
module flow_stage_packet_counter (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire fspc_pkg::req_t  in_req,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output fspc_pkg::rsp_t       out_rsp,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [0:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import fspc_pkg::*;

    logic      trace_reg;
    cell_cmd_t cmd;
    key_t      new_key;
    slot_t     ring [TableEntries];

    assign pready = 1'b1;
    assign prdata = {31'd0, trace_reg};

    // The register is the only one; paddr is decoded against its address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            trace_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == 1'b0)
            trace_reg <= pwdata[0];
    end

    fspc_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_req          (in_req),
        .tracing_enabled (trace_reg),
        .head            (ring[0]),
        .cmd             (cmd),
        .new_key         (new_key),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_rsp         (out_rsp)
    );

    // Cell i takes from cell i+1, so rotating brings the next slot to the head.
    for (genvar i = 0; i < TableEntries; i++)
    begin : g_cell
        fspc_cell u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .prev    (ring[(i + 1) % TableEntries]),
            .is_head (i == 0),
            .new_key (new_key),
            .cur     (ring[i])
        );
    end

    // A request is never taken while a result is still waiting.
    a_no_accept_with_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request accepted while a result waits");

    // A held result stays put while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_rsp)))
        else $error("stalled result changed");

    // Configuration writes read back.
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr == 1'b0) |=> (prdata[0] == $past(pwdata[0])))
        else $error("register write lost");
endmodule
`default_nettype wire

/* rtl/core/fspc_cell.sv */
// One flow slot of the ring: holds a key and five counters, passes them to its neighbor.
`default_nettype none
module fspc_cell (
    input  wire logic               clk,
    input  wire fspc_pkg::cell_cmd_t cmd,
    input  wire fspc_pkg::slot_t    prev,
    input  wire logic               is_head,
    input  wire fspc_pkg::key_t     new_key,
    output fspc_pkg::slot_t         cur
);
    import fspc_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;
    cnt_t  cmax;

    assign cmax = '1;
    assign cur  = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        if (cmd.rotate)
        begin
            slot_next = prev;
        end
        else if (is_head && cmd.load)
        begin
            slot_next.key = new_key;
            slot_next.cnt = '0;
        end
        else if (is_head && cmd.inc)
        begin
            for (int s = 0; s < Stages; s++)
            begin
                if (cmd.stage == 3'(s) && slot_reg.cnt[s] != cmax)
                    slot_next.cnt[s] = slot_reg.cnt[s] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end
endmodule
`default_nettype wire

/* rtl/core/fspc_ctrl.sv */
// Sequencer that rotates the cell ring for lookup, insert and dump.
`default_nettype none
module fspc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire fspc_pkg::req_t       in_req,
    input  wire logic                 tracing_enabled,
    input  wire fspc_pkg::slot_t      head,
    output fspc_pkg::cell_cmd_t       cmd,
    output fspc_pkg::key_t            new_key,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output fspc_pkg::rsp_t            out_rsp
);
    import fspc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_INC  = 3'd2;
    localparam logic [2:0] S_ALIGN = 3'd3;
    localparam logic [2:0] S_DUMP = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CountW-1:0] count_reg, count_next;
    // Rotation so far; the ring holds TableEntries cells, slot i sits at head after i steps.
    logic [SlotW:0]    pos_reg, pos_next;
    logic [SlotW:0]    idx_reg, idx_next;
    logic              found_reg, found_next;
    req_t              req_reg, req_next;
    logic              ov_reg, ov_next;
    rsp_t              rsp_reg, rsp_next;
    key_t              k;
    logic              accept, key_eq, ign, cell_done;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_rsp   = rsp_reg;
    assign k = '{proto: req_reg.ip_protocol, saddr: req_reg.src_addr,
                 sport: req_reg.src_port, daddr: req_reg.dst_addr,
                 dport: req_reg.dst_port};
    assign new_key = k;
    assign key_eq  = (head.key == k);
    assign ign = !tracing_enabled
              || !(in_req.ip_protocol == PROTO_TCP || in_req.ip_protocol == PROTO_UDP)
              || in_req.stage > 3'(Stages - 1);
    assign cell_done = (pos_reg == (SlotW + 1)'(TableEntries - 1));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        req_next   = req_reg;
        ov_next    = ov_reg;
        rsp_next   = rsp_reg;
        cmd        = '0;
        cmd.stage  = req_reg.stage;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next = in_req;
                    rsp_next = '0;
                    rsp_next.last = 1'b1;
                    pos_next = '0;
                    idx_next = '0;
                    found_next = 1'b0;
                    if (in_req.func == FUNC_COUNT)
                    begin
                        if (ign)
                        begin
                            rsp_next.status = ST_IGNORED;
                            ov_next = 1'b1;
                        end
                        else
                            state_next = S_SCAN;
                    end
                    else if (count_reg == '0)
                    begin
                        rsp_next.status = ST_EMPTY;
                        ov_next = 1'b1;
                    end
                    else
                        state_next = S_DUMP;
                end
            end
            S_SCAN:
            begin
                // Head holds slot pos_reg. Stop on a hit, at the first free slot or on a full table.
                if (pos_reg < (SlotW + 1)'(count_reg))
                begin
                    if (key_eq)
                    begin
                        found_next = 1'b1;
                        state_next = S_INC;
                    end
                    else
                    begin
                        cmd.rotate = 1'b1;
                        pos_next = pos_reg + 1'b1;
                    end
                end
                else if (count_reg == CountW'(TableEntries))
                begin
                    // A full lap has brought slot 0 back to the head.
                    rsp_next.status = ST_FULL;
                    ov_next = 1'b1;
                    pos_next = '0;
                    state_next = S_ALIGN;
                end
                else
                begin
                    cmd.load = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = S_INC;
                end
            end
            S_INC:
            begin
                cmd.inc = 1'b1;
                rsp_next.status = found_reg ? ST_COUNTED : ST_INSERTED;
                ov_next = 1'b1;
                state_next = S_ALIGN;
            end
            S_ALIGN:
            begin
                // Turn the ring back so slot 0 is at the head again.
                if (pos_reg == '0)
                    state_next = S_IDLE;
                else
                begin
                    cmd.rotate = 1'b1;
                    pos_next = cell_done ? '0 : pos_reg + 1'b1;
                end
            end
            S_DUMP:
            begin
                if (!ov_reg || !out_stall)
                begin
                    rsp_next.status        = ST_DUMP;
                    rsp_next.flow_protocol = head.key.proto;
                    rsp_next.flow_src_addr = head.key.saddr;
                    rsp_next.flow_src_port = head.key.sport;
                    rsp_next.flow_dst_addr = head.key.daddr;
                    rsp_next.flow_dst_port = head.key.dport;
                    rsp_next.count_eth_recv   = sat32(head.cnt[0]);
                    rsp_next.count_gro_recv   = sat32(head.cnt[1]);
                    rsp_next.count_netif_recv = sat32(head.cnt[2]);
                    rsp_next.count_tcp_recv   = sat32(head.cnt[3]);
                    rsp_next.count_xmit       = sat32(head.cnt[4]);
                    rsp_next.last = (idx_reg + 1'b1 == (SlotW + 1)'(count_reg));
                    ov_next = 1'b1;
                    cmd.rotate = 1'b1;
                    pos_next = cell_done ? '0 : pos_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                    if (rsp_next.last)
                    begin
                        count_next = '0;
                        state_next = S_ALIGN;
                        if (cell_done)
                            state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pos_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        found_reg <= found_next;
        req_reg   <= req_next;
        rsp_reg   <= rsp_next;
    end
endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the flow stage packet counter.
`timescale 1ns / 1ps
module tb_top;
    import fspc_pkg::*;

    // The watchdog only runs while work is pending. A count request may walk
    // the whole ring and a dump may run through all 64 flows, so a quiet run that
    // reaches HangLimit without any handshake means the block has hung.
    localparam int HangLimit   = 5000;
    // Quiet cycles after the last result, well past the ring walk.
    localparam int DrainCycles = 300;
    localparam int KeyPool     = 12;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    req_t        in_req;
    logic        out_valid;
    logic        out_stall;
    rsp_t        out_rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    flow_stage_packet_counter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Register index of the tracing switch.
    localparam logic [0:0] REG_TRACING = 1'b0;

    // Shadow copy of the flow table, kept in insertion order.
    key_t        shadow_keys [TableEntries];
    logic [31:0] shadow_cnt  [TableEntries][Stages];
    int          shadow_flows;
    logic        shadow_tracing;

    // Responses still owed by the block, oldest first.
    rsp_t        pending_rsp [$];

    int          error_count;
    int          send_idle_pct;
    int          stall_pct;
    int          quiet_cycles;
    key_t        key_pool [KeyPool];

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Work out every response that one accepted request causes and append
    // them to the pending queue; the shadow table is updated the same way the
    // block updates its own.
    task automatic predict_request(input req_t r);
        rsp_t rsp;
        key_t k;
        int   slot;
        rsp = '0;
        if (r.func != FUNC_COUNT)
        begin
            if (shadow_flows == 0)
            begin
                rsp.status = ST_EMPTY;
                rsp.last   = 1'b1;
                pending_rsp.push_back(rsp);
            end
            else
            begin
                for (int i = 0; i < shadow_flows; i++)
                begin
                    rsp = '0;
                    rsp.status           = ST_DUMP;
                    rsp.flow_protocol    = shadow_keys[i].proto;
                    rsp.flow_src_addr    = shadow_keys[i].saddr;
                    rsp.flow_src_port    = shadow_keys[i].sport;
                    rsp.flow_dst_addr    = shadow_keys[i].daddr;
                    rsp.flow_dst_port    = shadow_keys[i].dport;
                    rsp.count_eth_recv   = shadow_cnt[i][0];
                    rsp.count_gro_recv   = shadow_cnt[i][1];
                    rsp.count_netif_recv = shadow_cnt[i][2];
                    rsp.count_tcp_recv   = shadow_cnt[i][3];
                    rsp.count_xmit       = shadow_cnt[i][4];
                    rsp.last             = (i == shadow_flows - 1);
                    pending_rsp.push_back(rsp);
                end
                shadow_flows = 0;
            end
            return;
        end
        rsp.last = 1'b1;
        // Tracing off, a protocol other than TCP or UDP, or a stage code past
        // the transmit stage all leave the table alone.
        if (!shadow_tracing || (r.ip_protocol != PROTO_TCP && r.ip_protocol != PROTO_UDP)
            || r.stage >= Stages)
        begin
            rsp.status = ST_IGNORED;
            pending_rsp.push_back(rsp);
            return;
        end
        k.proto = r.ip_protocol;
        k.saddr = r.src_addr;
        k.sport = r.src_port;
        k.daddr = r.dst_addr;
        k.dport = r.dst_port;
        slot = -1;
        for (int i = 0; i < shadow_flows; i++)
        begin
            if (slot < 0 && shadow_keys[i] == k)
                slot = i;
        end
        if (slot >= 0)
        begin
            rsp.status = ST_COUNTED;
        end
        else if (shadow_flows >= TableEntries)
        begin
            rsp.status = ST_FULL;
            pending_rsp.push_back(rsp);
            return;
        end
        else
        begin
            slot = shadow_flows;
            shadow_keys[slot] = k;
            for (int j = 0; j < Stages; j++)
                shadow_cnt[slot][j] = '0;
            shadow_flows++;
            rsp.status = ST_INSERTED;
        end
        if (shadow_cnt[slot][r.stage] != 32'hFFFF_FFFF)
            shadow_cnt[slot][r.stage] = shadow_cnt[slot][r.stage] + 32'd1;
        pending_rsp.push_back(rsp);
    endtask

    // Present one request, after an optional random gap, and hold it until
    // the block takes it. Entered and left at a falling edge.
    task automatic send_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_req   = r;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        predict_request(r);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic req_t make_count(input logic [2:0] stage, input key_t k);
        req_t r;
        r.func        = FUNC_COUNT;
        r.stage       = stage;
        r.ip_protocol = k.proto;
        r.src_addr    = k.saddr;
        r.src_port    = k.sport;
        r.dst_addr    = k.daddr;
        r.dst_port    = k.dport;
        return r;
    endfunction

    function automatic req_t make_dump();
        req_t r;
        r       = req_t'($bits(req_t)'({$urandom, $urandom, $urandom, $urandom}));
        r.func  = ~FUNC_COUNT;
        return r;
    endfunction

    function automatic key_t random_key(input logic [7:0] proto);
        key_t k;
        k.proto = proto;
        k.saddr = $urandom;
        k.sport = 16'($urandom_range(16'hFFFF));
        k.daddr = $urandom;
        k.dport = 16'($urandom_range(16'hFFFF));
        return k;
    endfunction

    // Block until the block owes nothing; the watchdog guards a hang.
    task automatic wait_idle();
        while (pending_rsp.size() != 0)
            @(negedge clk);
    endtask

    // Two-phase register write; pready is always high, so the access phase
    // completes at the first rising edge.
    task automatic write_reg(input logic [0:0] addr, input logic [31:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (addr == REG_TRACING)
            shadow_tracing = value[0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_tracing(input logic on);
        wait_idle();
        write_reg(REG_TRACING, {31'd0, on});
    endtask

    // The receiver stall changes at every falling edge.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Each response taken by the testbench is matched against the oldest
    // pending prediction.
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response with none pending: status %0d", out_rsp.status);
                error_count++;
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                check_field("status", exp_rsp.status, out_rsp.status);
                check_field("flow_protocol", exp_rsp.flow_protocol, out_rsp.flow_protocol);
                check_field("flow_src_addr", exp_rsp.flow_src_addr, out_rsp.flow_src_addr);
                check_field("flow_src_port", exp_rsp.flow_src_port, out_rsp.flow_src_port);
                check_field("flow_dst_addr", exp_rsp.flow_dst_addr, out_rsp.flow_dst_addr);
                check_field("flow_dst_port", exp_rsp.flow_dst_port, out_rsp.flow_dst_port);
                check_field("count_eth_recv", exp_rsp.count_eth_recv, out_rsp.count_eth_recv);
                check_field("count_gro_recv", exp_rsp.count_gro_recv, out_rsp.count_gro_recv);
                check_field("count_netif_recv", exp_rsp.count_netif_recv,
                            out_rsp.count_netif_recv);
                check_field("count_tcp_recv", exp_rsp.count_tcp_recv, out_rsp.count_tcp_recv);
                check_field("count_xmit", exp_rsp.count_xmit, out_rsp.count_xmit);
                check_field("last", exp_rsp.last, out_rsp.last);
            end
        end
    end

    // Watchdog: counts cycles with work pending but no handshake on either
    // channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
            || (pending_rsp.size() == 0 && !in_valid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HangLimit)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Directed checks of the basic cases: tracing off, empty dump, insert and
    // hit, both protocols, every stage, out-of-range stages, other protocols,
    // and all-zero and all-one keys.
    task automatic test_directed();
        key_t k_tcp;
        key_t k_udp;
        key_t k_ones;
        key_t k_zero;
        k_tcp  = random_key(PROTO_TCP);
        k_udp  = random_key(PROTO_UDP);
        k_ones = '{proto: PROTO_UDP, saddr: '1, sport: '1, daddr: '1, dport: '1};
        k_zero = '{proto: PROTO_TCP, saddr: '0, sport: '0, daddr: '0, dport: '0};
        send_request(make_count(3'd0, k_tcp));        // ignored while tracing is off
        send_request(make_dump());                    // empty table
        set_tracing(1'b1);
        send_request(make_count(3'd0, k_tcp));        // new flow
        send_request(make_count(3'd0, k_tcp));        // same flow again
        for (int s = 1; s < Stages; s++)
            send_request(make_count(3'(s), k_tcp));
        send_request(make_count(3'd4, k_udp));
        send_request(make_count(3'd3, k_ones));
        send_request(make_count(3'd2, k_zero));
        for (int s = Stages; s < 8; s++)
            send_request(make_count(3'(s), k_udp));   // stage codes past transmit
        send_request(make_count(3'd1, random_key(8'd0)));
        send_request(make_count(3'd1, random_key(8'hFF)));
        send_request(make_dump());
        send_request(make_dump());                    // table is empty again
    endtask

    // Fill the table to its capacity, then offer one more new flow and an old
    // one, and dump the whole table.
    task automatic test_table_full();
        key_t k_first;
        k_first = random_key(PROTO_TCP);
        send_request(make_count(3'd0, k_first));
        for (int i = 1; i < TableEntries; i++)
            send_request(make_count(3'($urandom_range(Stages - 1)),
                                    random_key($urandom_range(1) ? PROTO_TCP : PROTO_UDP)));
        send_request(make_count(3'd2, random_key(PROTO_UDP)));
        send_request(make_count(3'd1, k_first));
        send_request(make_dump());
    endtask

    // Random traffic: mostly well-formed counts over a small set of flows so
    // that hits, inserts and dumps all occur, with some noise mixed in.
    task automatic test_random(input int items, input int tracing_off_items,
                               input logic hold_midway);
        int pick;
        for (int i = 0; i < KeyPool; i++)
            key_pool[i] = random_key($urandom_range(1) ? PROTO_TCP : PROTO_UDP);
        set_tracing(1'b0);
        for (int i = 0; i < items; i++)
        begin
            if (i == tracing_off_items)
                set_tracing(1'b1);
            // The sender holds off until everything owed has come back.
            if (hold_midway && i == items / 2)
                wait_idle();
            pick = $urandom_range(99);
            if (pick < 72)
                send_request(make_count(3'($urandom_range(Stages - 1)),
                                        key_pool[$urandom_range(KeyPool - 1)]));
            else if (pick < 80)
                send_request(make_count(3'($urandom_range(Stages - 1)),
                                        random_key($urandom_range(1) ? PROTO_TCP : PROTO_UDP)));
            else if (pick < 91)
                send_request(req_t'({FUNC_COUNT, 3'($urandom_range(7)),
                                     8'($urandom_range(255)), $urandom, 16'($urandom),
                                     $urandom, 16'($urandom)}));
            else
                send_request(make_dump());
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_req        = '0;
        out_stall     = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        shadow_flows  = 0;
        shadow_tracing = 1'b0;
        error_count   = 0;
        quiet_cycles  = 0;
        send_idle_pct = 16;
        stall_pct     = 62;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_table_full();
        test_random(40, 10, 1'b1);

        wait_idle();
        send_idle_pct = 62;
        stall_pct     = 16;
        test_random(40, 15, 1'b0);

        wait_idle();
        send_idle_pct = 0;
        stall_pct     = 0;
        test_random(40, 5, 1'b0);

        wait_idle();
        repeat (DrainCycles) @(posedge clk);
        if (error_count == 0 && pending_rsp.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
